FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that cons holds in the same cycle as ante
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// assert that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/cobs_enc_pkg.sv
package cobs_enc_pkg;

    localparam int MAX_INPUT_BYTES = 256;
    localparam int BR_W            = $clog2(MAX_INPUT_BYTES + 1);
    localparam int POS_W           = 9;
    localparam int BYTE_W          = 8;
    localparam int NUM_SLOTS       = 4;
    localparam int SLOT_W          = $clog2(NUM_SLOTS);

    localparam logic [BYTE_W-1:0] RUN_START = 8'h01;
    localparam logic [BYTE_W-1:0] RUN_CLOSE = 8'hFF;

    // result slots, in delivery order
    localparam logic [SLOT_W-1:0] SLOT_MAIN  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_CLOSE = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_CODE  = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_FLAG  = 2'd3;

    // register word index
    localparam logic REG_FLAG_BYTE = 1'b0;

    typedef struct packed {
        logic [POS_W-1:0]  idx;
        logic [BYTE_W-1:0] val;
    } slot_t;

endpackage

FILE: rtl/cobs_style_byte_stuffing_encoder.sv
// Channel   Direction  tdata (low bit up)                                  tuser/tlast
// s_        in         data_byte[7:0]                                      tlast = last_byte
// m_        out        write_index[8:0], write_value[16:9], total_length    tlast = end_of_packet
//                      [25:17], zero fill to 32 bits
// apb       in/out     flag_byte at byte address 0
//
// One input byte is taken per cycle while s_tready is high; it yields zero to four writes,
// delivered one per cycle while m_tready is high from a four-slot result register. A byte with
// at most one write is followed by the next byte in the next cycle if m_tready is high;
// more writes hold s_tready low until one is left; the m_ side stalls the s_ side only
// through that register. Reset (aresetn low, synchronous) clears encoder state and flag_byte.
module cobs_style_byte_stuffing_encoder import cobs_enc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // write_index[8:0], write_value[16:9], total_length[25:17]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [BYTE_W-1:0]    flag_reg;
    logic [BR_W-1:0]      bytes_read_reg, bytes_read_next;
    logic [POS_W-1:0]     nwp_reg, nwp_next;
    logic [POS_W-1:0]     pcp_reg, pcp_next;
    logic [BYTE_W-1:0]    run_code_reg, run_code_next;
    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    slot_t                slot_reg [NUM_SLOTS];
    slot_t                slot_new [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] mask_new;
    logic [POS_W-1:0]     len_reg, len_new;

    logic [BYTE_W-1:0]    data_byte;
    logic                 in_range, is_flag;
    logic [BYTE_W-1:0]    code_inc;
    logic [POS_W-1:0]     nwp_inc;
    logic [POS_W-1:0]     nwp_adv, pcp_adv;
    logic [BYTE_W-1:0]    rc_adv;
    logic                 s_accept, m_accept, mask_single;
    logic [NUM_SLOTS-1:0] mask_rem;
    logic [SLOT_W-1:0]    sel;
    logic                 cfg_write;

    assign data_byte = s_tdata[BYTE_W-1:0];
    assign in_range  = bytes_read_reg < BR_W'(MAX_INPUT_BYTES);
    assign is_flag   = data_byte == flag_reg;
    assign code_inc  = run_code_reg + RUN_START;
    assign nwp_inc   = nwp_reg + POS_W'(1);

    always_comb begin
        nwp_adv  = nwp_reg;
        pcp_adv  = pcp_reg;
        rc_adv   = run_code_reg;
        mask_new = '0;
        if (in_range) begin
            mask_new[SLOT_MAIN] = 1'b1;
            nwp_adv = nwp_inc;
            if (is_flag) begin
                rc_adv  = RUN_START;
                pcp_adv = nwp_reg;
            end else if (code_inc == flag_reg) begin
                rc_adv = code_inc + RUN_START;
            end else if (code_inc == RUN_CLOSE) begin
                mask_new[SLOT_CLOSE] = 1'b1;
                rc_adv  = RUN_START;
                pcp_adv = nwp_inc;
                nwp_adv = nwp_inc + POS_W'(1);
            end else begin
                rc_adv = code_inc;
            end
        end
        if (s_tlast) begin
            mask_new[SLOT_CODE] = 1'b1;
            mask_new[SLOT_FLAG] = 1'b1;
        end
        slot_new[SLOT_MAIN]  = is_flag ? slot_t'{idx: pcp_reg, val: run_code_reg}
                                       : slot_t'{idx: nwp_reg, val: data_byte};
        slot_new[SLOT_CLOSE] = '{idx: pcp_reg, val: RUN_CLOSE};
        slot_new[SLOT_CODE]  = '{idx: pcp_adv, val: rc_adv};
        slot_new[SLOT_FLAG]  = '{idx: nwp_adv, val: flag_reg};
        len_new = nwp_adv + POS_W'(1);
    end

    always_comb begin
        bytes_read_next = bytes_read_reg;
        nwp_next        = nwp_reg;
        pcp_next        = pcp_reg;
        run_code_next   = run_code_reg;
        if (s_accept) begin
            if (s_tlast) begin
                bytes_read_next = '0;
                nwp_next        = POS_W'(1);
                pcp_next        = '0;
                run_code_next   = RUN_START;
            end else begin
                if (in_range) begin
                    bytes_read_next = bytes_read_reg + BR_W'(1);
                end
                nwp_next      = nwp_adv;
                pcp_next      = pcp_adv;
                run_code_next = rc_adv;
            end
        end
    end

    // pick the lowest pending slot
    always_comb begin
        sel = SLOT_FLAG;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign mask_rem    = mask_reg & (mask_reg - NUM_SLOTS'(1));
    assign mask_single = mask_rem == '0;
    assign m_tvalid    = mask_reg != '0;
    assign m_accept    = m_tvalid && m_tready;
    assign s_tready    = mask_single && (!m_tvalid || m_tready);
    assign s_accept    = s_tvalid && s_tready;

    always_comb begin
        mask_next = mask_reg;
        if (s_accept) begin
            mask_next = mask_new;
        end else if (m_accept) begin
            mask_next = mask_rem;
        end
    end

    assign m_tlast = sel == SLOT_FLAG;
    assign m_tdata = {6'b0, (m_tlast ? len_reg : POS_W'(0)), slot_reg[sel].val,
                      slot_reg[sel].idx};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_FLAG_BYTE);
    assign prdata    = (paddr[2] == REG_FLAG_BYTE) ? {24'b0, flag_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg       <= '0;
            bytes_read_reg <= '0;
            nwp_reg        <= POS_W'(1);
            pcp_reg        <= '0;
            run_code_reg   <= RUN_START;
            mask_reg       <= '0;
        end else begin
            if (cfg_write) begin
                flag_reg <= pwdata[BYTE_W-1:0];
            end
            bytes_read_reg <= bytes_read_next;
            nwp_reg        <= nwp_next;
            pcp_reg        <= pcp_next;
            run_code_reg   <= run_code_next;
            mask_reg       <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_reg[i] <= slot_new[i];
            end
            len_reg <= len_new;
        end
    end

endmodule

FILE: rtl/cobs_enc_checker.sv
`include "assert_macros.svh"

module cobs_enc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    `ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `ASSERT_SAME(a_len_on_last, aclk, aresetn, m_tvalid && m_tlast, m_tdata[25:17] == m_tdata[8:0] + 9'd1)
    `ASSERT_SAME(a_len_zero, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[25:17] == 9'd0)
    `ASSERT_NEXT(a_last_gives_output, aclk, aresetn, s_tvalid && s_tready && s_tlast, m_tvalid)

endmodule

bind cobs_style_byte_stuffing_encoder cobs_enc_checker u_cobs_enc_checker (.*);

FILE: tb/sv/cobs_style_byte_stuffing_encoder_tb.sv
`timescale 1ns / 1ps

module cobs_style_byte_stuffing_encoder_tb import cobs_enc_pkg::*; ();

    localparam int               WATCHDOG_LIMIT = 2000;
    localparam int               SETTLE_CYCLES  = 16;
    localparam int               RANDOM_ITEMS   = 120;
    localparam logic [2:0]       FLAG_BYTE_ADDR = {REG_FLAG_BYTE, 2'b00};

    typedef struct packed {
        logic [POS_W-1:0]  idx;
        logic [BYTE_W-1:0] val;
        logic              eop;
        logic [POS_W-1:0]  len;
    } buf_write_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte[7:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // write_index[8:0], write_value[16:9], total_length[25:17]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    buf_write_t        pending_writes[$];
    logic [BYTE_W-1:0] flag_shadow;
    int                bytes_seen;
    logic [POS_W-1:0]  next_pos;
    logic [POS_W-1:0]  code_pos;
    logic [BYTE_W-1:0] run_code;

    int       fail_count;
    int       idle_cycles;
    bit       moved;
    int       burst_left;
    bit       tx_gaps;
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_phase;

    cobs_style_byte_stuffing_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void push_write(logic [POS_W-1:0] idx, logic [BYTE_W-1:0] val,
                                       logic eop, logic [POS_W-1:0] len);
        buf_write_t w;
        w.idx = idx;
        w.val = val;
        w.eop = eop;
        w.len = len;
        pending_writes.push_back(w);
    endfunction

    function automatic void restart_packet();
        bytes_seen = 0;
        next_pos   = POS_W'(1);
        code_pos   = '0;
        run_code   = RUN_START;
    endfunction

    function automatic void close_run();
        push_write(code_pos, run_code, 1'b0, '0);
        run_code = RUN_START;
        code_pos = next_pos;
        next_pos = next_pos + 1'b1;
    endfunction

    function automatic void encode_byte(logic [BYTE_W-1:0] data, logic last);
        logic [POS_W-1:0] flag_pos;
        if (bytes_seen < MAX_INPUT_BYTES) begin
            bytes_seen++;
            if (data == flag_shadow) begin
                close_run();
            end else begin
                push_write(next_pos, data, 1'b0, '0);
                next_pos = next_pos + 1'b1;
                run_code = run_code + 1'b1;
                if (run_code == flag_shadow) begin
                    run_code = run_code + 1'b1;
                end else if (run_code == RUN_CLOSE) begin
                    close_run();
                end
            end
        end
        if (last) begin
            flag_pos = next_pos;
            push_write(code_pos, run_code, 1'b0, '0);
            push_write(flag_pos, flag_shadow, 1'b1, flag_pos + 1'b1);
            restart_packet();
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            flag_shadow = '0;
            restart_packet();
            pending_writes.delete();
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (psel && penable && pwrite && pready) begin
                if (paddr == FLAG_BYTE_ADDR) begin
                    flag_shadow = pwdata[BYTE_W-1:0];
                end
                moved = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (pending_writes.size() == 0) begin
                    $error("unexpected write: index %0d value %0h", m_tdata[8:0], m_tdata[16:9]);
                    fail_count++;
                end else begin
                    if (m_tdata[8:0] !== pending_writes[0].idx) begin
                        $error("write_index: expected %0d, got %0d",
                               pending_writes[0].idx, m_tdata[8:0]);
                        fail_count++;
                    end
                    if (m_tdata[16:9] !== pending_writes[0].val) begin
                        $error("write_value: expected %0h, got %0h",
                               pending_writes[0].val, m_tdata[16:9]);
                        fail_count++;
                    end
                    if (m_tlast !== pending_writes[0].eop) begin
                        $error("end_of_packet: expected %0d, got %0d",
                               pending_writes[0].eop, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[25:17] !== pending_writes[0].len) begin
                        $error("total_length: expected %0d, got %0d",
                               pending_writes[0].len, m_tdata[25:17]);
                        fail_count++;
                    end
                    void'(pending_writes.pop_front());
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(64, 256);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_phase % 4 == 0);
            default:   m_tready <= (rx_phase % 8 < 3);
        endcase
    end

    task automatic send_byte(logic [7:0] data, logic last);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = tx_gaps ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, wait for every pending write, then let the pipeline settle
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_flag(logic [7:0] value);
        wait_drain();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FLAG_BYTE_ADDR;
        pwdata  <= {24'h0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return flag_shadow;
        if (r < 30) return 8'h00;
        if (r < 35) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_flag_in_data();
        tx_gaps = 1'b1;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h33, 1'b1);
    endtask

    task automatic test_high_flags();
        set_flag(8'hFF);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        set_flag(8'hFE);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        set_flag(8'h01);
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [7:0] flags[6];
        int         sent;
        int         len;
        flags = '{8'($urandom_range(0, 255)), 8'h00, 8'hFF, 8'hFE, 8'h01,
                  8'($urandom_range(0, 255))};
        for (int ph = 0; ph < 6; ph++) begin
            set_flag(flags[ph]);
            tx_gaps = (ph % 2 == 0);
            sent = 0;
            while (sent < RANDOM_ITEMS / 6) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 19) == 0) wait_drain();
                    send_byte(pick_byte(), i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b1;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fail_count = 0;
        burst_left = 0;
        tx_gaps    = 1'b1;
        rx_left    = 0;
        rx_phase   = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_flag_in_data();
        test_high_flags();
        test_random_traffic();
        wait_drain();

        if (fail_count == 0 && pending_writes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
